FILE: rtl/bpd_pkg.sv
// bpd_pkg: shared widths, constants, register indexes and stage structs
// for the balance pid dual pwm core. No dependencies.
`default_nettype none

package bpd_pkg;

  // field widths
  localparam int ANGLE_W        = 16;
  localparam int ERR_W          = 17;
  localparam int DIFF_W         = 18;
  localparam int GAIN_W         = 15;
  localparam int DUTY_W         = 12;
  localparam int INTEGRAL_WIDTH = 24;
  localparam int ISUM_W         = INTEGRAL_WIDTH + 1;

  // product and sum widths (gain is unsigned, widened by one sign bit)
  localparam int PROD_P_W = GAIN_W + ERR_W + 1;
  localparam int PROD_I_W = GAIN_W + INTEGRAL_WIDTH + 1;
  localparam int PROD_D_W = GAIN_W + DIFF_W + 1;
  localparam int SUM_W    = ((PROD_I_W > PROD_D_W) ? PROD_I_W : PROD_D_W) + 2;

  // divide by 1000: shift out 3 bits (divide by 8), then multiply by the reciprocal of 125
  localparam int GAIN_SCALE = 1000;
  localparam int U_LIMIT    = 8192;
  localparam int SAT_LIMIT  = U_LIMIT * GAIN_SCALE;
  localparam int Q_W        = 14;
  localparam int DIV_PRE    = 3;
  localparam int DIV_X_W    = 20;
  localparam int RECIP_W    = 21;
  localparam int DIV_SHIFT  = 27;
  localparam int DIV_PROD_W = DIV_X_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_125 = 21'd1073742;

  // duty arithmetic
  localparam int VAL_W = 16;
  localparam logic [DUTY_W-1:0] DUTY_MIN   = 12'd3;
  localparam logic [DUTY_W-1:0] DUTY_MAX   = 12'd4000;
  localparam logic [DUTY_W-1:0] HOLD_RESET = 12'd2000;

  // configuration reset values
  localparam logic [GAIN_W-1:0]  KP_RESET     = 15'd1000;
  localparam logic [GAIN_W-1:0]  KI_RESET     = 15'd0;
  localparam logic [GAIN_W-1:0]  KD_RESET     = 15'd5000;
  localparam logic [ANGLE_W-1:0] OFFSET_RESET = 16'd0;
  localparam logic [DUTY_W-1:0]  LPOS_RESET   = 12'd1823;
  localparam logic [DUTY_W-1:0]  LNEG_RESET   = 12'd2193;
  localparam logic [DUTY_W-1:0]  RPOS_RESET   = 12'd1857;
  localparam logic [DUTY_W-1:0]  RNEG_RESET   = 12'd2148;

  // apb register map
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;
  localparam int DATA_W    = 32;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_KP,
    REG_KI,
    REG_KD,
    REG_OFFSET,
    REG_LPOS,
    REG_LNEG,
    REG_RPOS,
    REG_RNEG
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]         kp;
    logic [GAIN_W-1:0]         ki;
    logic [GAIN_W-1:0]         kd;
    logic signed [ANGLE_W-1:0] angle_offset;
    logic [DUTY_W-1:0]         left_pos_base;
    logic [DUTY_W-1:0]         left_neg_base;
    logic [DUTY_W-1:0]         right_pos_base;
    logic [DUTY_W-1:0]         right_neg_base;
  } cfg_t;

  // per-item data carried to the duty stage
  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic                    err_pos;
    logic                    err_neg;
    logic                    prev_pos;
    logic                    prev_neg;
  } tag_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0]         diff;
    logic signed [INTEGRAL_WIDTH-1:0] integ;
    tag_t                             tag;
  } front_t;

  typedef struct packed {
    logic [Q_W-1:0] q;
    logic           neg;
    tag_t           tag;
  } scale_t;

endpackage

`default_nettype wire

FILE: rtl/balance_pid_dual_pwm_core.sv
// balance_pid_dual_pwm_core: top level of the pid balance controller with
// two pwm compare outputs. Depends on bpd_pkg and all bpd_* modules.
//
//   channel   signals                                     direction
//   input     in_valid, in_ready, tilt_angle              item in
//   output    out_valid, out_ready, left_duty,
//             right_duty, angle_error                     item out
//   config    psel, penable, pwrite, paddr, pwdata,
//             prdata, pready                              apb slave
//
// One item per clock sustained while out_ready is high; a result passes the
// front register, four product/sum/divide stages and the duty register in
// that order. Each stage holds while the one after it is full, so
// a stalled output backs up stage by stage while earlier stages still fill.
// Synchronous reset clears valids and controller state, and sets held duties
// (2000) and the configuration registers to their reset values.
`default_nettype none

module balance_pid_dual_pwm_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [bpd_pkg::ANGLE_W-1:0] tilt_angle,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bpd_pkg::DUTY_W-1:0]        left_duty,
  output logic [bpd_pkg::DUTY_W-1:0]        right_duty,
  output logic signed [bpd_pkg::ERR_W-1:0]  angle_error,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bpd_pkg::ADDR_W-1:0]        paddr,
  input  logic [bpd_pkg::DATA_W-1:0]        pwdata,
  output logic [bpd_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);
  import bpd_pkg::*;

  cfg_t   cfg;
  logic   f_valid, f_ready;
  front_t f_data;
  logic   s_valid, s_ready;
  scale_t s_data;

  // configuration registers
  bpd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // error, difference and integral
  bpd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .tilt_angle (tilt_angle),
    .s_valid    (f_valid),
    .s_ready    (f_ready),
    .s_data     (f_data)
  );

  // gains and divide by 1000
  bpd_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_data  (s_data)
  );

  // duty selection and result register
  bpd_duty u_duty (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_valid),
    .in_ready    (s_ready),
    .in_data     (s_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .left_duty   (left_duty),
    .right_duty  (right_duty),
    .angle_error (angle_error)
  );

endmodule

`default_nettype wire

FILE: rtl/bpd_regs.sv
// bpd_regs: apb configuration registers of the balance pid core.
// Depends on bpd_pkg.
`default_nettype none

module bpd_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bpd_pkg::ADDR_W-1:0] paddr,
  input  logic [bpd_pkg::DATA_W-1:0] pwdata,
  output logic [bpd_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output bpd_pkg::cfg_t              cfg
);
  import bpd_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp             <= KP_RESET;
      cfg.ki             <= KI_RESET;
      cfg.kd             <= KD_RESET;
      cfg.angle_offset   <= OFFSET_RESET;
      cfg.left_pos_base  <= LPOS_RESET;
      cfg.left_neg_base  <= LNEG_RESET;
      cfg.right_pos_base <= RPOS_RESET;
      cfg.right_neg_base <= RNEG_RESET;
    end else if (wr) begin
      case (idx)
        REG_KP:     cfg.kp             <= pwdata[GAIN_W-1:0];
        REG_KI:     cfg.ki             <= pwdata[GAIN_W-1:0];
        REG_KD:     cfg.kd             <= pwdata[GAIN_W-1:0];
        REG_OFFSET: cfg.angle_offset   <= pwdata[ANGLE_W-1:0];
        REG_LPOS:   cfg.left_pos_base  <= pwdata[DUTY_W-1:0];
        REG_LNEG:   cfg.left_neg_base  <= pwdata[DUTY_W-1:0];
        REG_RPOS:   cfg.right_pos_base <= pwdata[DUTY_W-1:0];
        REG_RNEG:   cfg.right_neg_base <= pwdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_KP:     prdata = DATA_W'(cfg.kp);
      REG_KI:     prdata = DATA_W'(cfg.ki);
      REG_KD:     prdata = DATA_W'(cfg.kd);
      REG_OFFSET: prdata = DATA_W'($signed(cfg.angle_offset));
      REG_LPOS:   prdata = DATA_W'(cfg.left_pos_base);
      REG_LNEG:   prdata = DATA_W'(cfg.left_neg_base);
      REG_RPOS:   prdata = DATA_W'(cfg.right_pos_base);
      REG_RNEG:   prdata = DATA_W'(cfg.right_neg_base);
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/bpd_front.sv
// bpd_front: input register stage; forms the error, difference and
// saturating integral and keeps prev_error / error_integral. Uses bpd_pkg.
`default_nettype none

module bpd_front (
  input  logic                        clk,
  input  logic                        rst,
  input  bpd_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [bpd_pkg::ANGLE_W-1:0] tilt_angle,
  output logic                        s_valid,
  input  logic                        s_ready,
  output bpd_pkg::front_t             s_data
);
  import bpd_pkg::*;

  logic signed [ERR_W-1:0]          prev_error;
  logic signed [INTEGRAL_WIDTH-1:0] error_integral;
  logic signed [ERR_W-1:0]          err;
  logic signed [DIFF_W-1:0]         diff;
  logic signed [ISUM_W-1:0]         isum;
  logic signed [INTEGRAL_WIDTH-1:0] integral_next;
  logic                             accept;
  tag_t                             tag;

  assign in_ready = !s_valid || s_ready;
  assign accept   = in_valid && in_ready;

  // error and difference
  always_comb begin
    err  = ERR_W'(tilt_angle) - ERR_W'(cfg.angle_offset);
    diff = DIFF_W'(err) - DIFF_W'(prev_error);
  end

  // saturating integral
  always_comb begin
    isum = ISUM_W'(err) + ISUM_W'(error_integral);
    if (isum[ISUM_W-1] != isum[ISUM_W-2]) begin
      integral_next = isum[ISUM_W-1] ? {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}}
                                     : {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
    end else begin
      integral_next = isum[INTEGRAL_WIDTH-1:0];
    end
  end

  // sign flags for the duty stage
  always_comb begin
    tag.err      = err;
    tag.err_pos  = !err[ERR_W-1] && (err != '0);
    tag.err_neg  = err[ERR_W-1];
    tag.prev_pos = !prev_error[ERR_W-1] && (prev_error != '0);
    tag.prev_neg = prev_error[ERR_W-1];
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error     <= '0;
      error_integral <= '0;
    end else if (accept) begin
      prev_error     <= err;
      error_integral <= integral_next;
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_data.diff  <= diff;
      s_data.integ <= integral_next;
      s_data.tag   <= tag;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bpd_scale.sv
// bpd_scale: gain products, their sum and the truncating divide by 1000,
// as four register stages. Uses bpd_pkg.
`default_nettype none

module bpd_scale (
  input  logic            clk,
  input  logic            rst,
  input  bpd_pkg::cfg_t   cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  bpd_pkg::front_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output bpd_pkg::scale_t out_data
);
  import bpd_pkg::*;

  // stage valids and enables
  logic v1, v2, v3;
  logic en1, en2, en3, en4;

  // stage 1: products
  logic signed [PROD_P_W-1:0] prod_p;
  logic signed [PROD_I_W-1:0] prod_i;
  logic signed [PROD_D_W-1:0] prod_d;
  tag_t                       tag1;
  // stage 2: sum
  logic signed [SUM_W-1:0]    sum;
  tag_t                       tag2;
  // stage 3: magnitude prepared for the reciprocal multiply
  logic [SUM_W-1:0]           mag;
  logic [DIV_X_W-1:0]         div_x;
  logic                       neg3;
  logic                       sat3;
  tag_t                       tag3;
  // stage 4 input
  logic [DIV_PROD_W-1:0]      div_prod;

  assign en4      = !out_valid || out_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) out_valid <= v3;
    end
  end

  // gain products
  always_ff @(posedge clk) begin
    if (en1) begin
      prod_p <= $signed({1'b0, cfg.kp}) * in_data.tag.err;
      prod_i <= $signed({1'b0, cfg.ki}) * in_data.integ;
      prod_d <= $signed({1'b0, cfg.kd}) * in_data.diff;
      tag1   <= in_data.tag;
    end
  end

  // sum of the three terms
  always_ff @(posedge clk) begin
    if (en2) begin
      sum  <= SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
      tag2 <= tag1;
    end
  end

  // magnitude, saturation past the clamp range, pre-divide by 8 (shift out 3 bits)
  assign mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  always_ff @(posedge clk) begin
    if (en3) begin
      div_x <= mag[DIV_PRE +: DIV_X_W];
      sat3  <= (mag >= SUM_W'(SAT_LIMIT));
      neg3  <= sum[SUM_W-1];
      tag3  <= tag2;
    end
  end

  // quotient by 125 via reciprocal multiply
  assign div_prod = DIV_PROD_W'(div_x) * DIV_PROD_W'(RECIP_125);

  always_ff @(posedge clk) begin
    if (en4) begin
      out_data.q   <= sat3 ? Q_W'(U_LIMIT) : div_prod[DIV_SHIFT +: Q_W];
      out_data.neg <= neg3;
      out_data.tag <= tag3;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bpd_duty.sv
// bpd_duty: per-side base selection, clamp and held duty values; the
// held values are the result register. Uses bpd_pkg.
`default_nettype none

module bpd_duty (
  input  logic                             clk,
  input  logic                             rst,
  input  bpd_pkg::cfg_t                    cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bpd_pkg::scale_t                  in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bpd_pkg::DUTY_W-1:0]       left_duty,
  output logic [bpd_pkg::DUTY_W-1:0]       right_duty,
  output logic signed [bpd_pkg::ERR_W-1:0] angle_error
);
  import bpd_pkg::*;

  logic              load;
  logic [DUTY_W-1:0] left_next;
  logic [DUTY_W-1:0] right_next;

  function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [VAL_W-1:0] v);
    logic [DUTY_W-1:0] r;
    if (v > $signed(VAL_W'(DUTY_MAX))) begin
      r = DUTY_MAX;
    end else if (v < $signed(VAL_W'(DUTY_MIN))) begin
      r = DUTY_MIN;
    end else begin
      r = v[DUTY_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [DUTY_W-1:0] side_duty(
    input tag_t              t,
    input logic [Q_W-1:0]    q,
    input logic              neg,
    input logic [DUTY_W-1:0] pos_base,
    input logic [DUTY_W-1:0] neg_base,
    input logic [DUTY_W-1:0] hold
  );
    logic [DUTY_W-1:0]       base;
    logic signed [VAL_W-1:0] v;
    logic [DUTY_W-1:0]       r;
    base = t.err_pos ? pos_base : neg_base;
    v    = neg ? $signed(VAL_W'(base)) + $signed(VAL_W'(q))
               : $signed(VAL_W'(base)) - $signed(VAL_W'(q));
    if (t.err_pos || t.err_neg) begin
      r = clamp_duty(v);
    end else if (t.prev_pos) begin
      r = clamp_duty($signed(VAL_W'(pos_base)));
    end else if (t.prev_neg) begin
      r = clamp_duty($signed(VAL_W'(neg_base)));
    end else begin
      r = hold;
    end
    return r;
  endfunction

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  // next duty per side
  always_comb begin
    left_next  = side_duty(in_data.tag, in_data.q, in_data.neg,
                           cfg.left_pos_base, cfg.left_neg_base, left_duty);
    right_next = side_duty(in_data.tag, in_data.q, in_data.neg,
                           cfg.right_pos_base, cfg.right_neg_base, right_duty);
  end

  // result register, doubling as the held duty values
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      left_duty  <= HOLD_RESET;
      right_duty <= HOLD_RESET;
    end else begin
      if (in_ready) out_valid <= in_valid;
      if (load) begin
        left_duty  <= left_next;
        right_duty <= right_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      angle_error <= in_data.tag.err;
    end
  end

  // outputs always inside the clamp range
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_duty >= DUTY_MIN) && (left_duty <= DUTY_MAX) &&
                  (right_duty >= DUTY_MIN) && (right_duty <= DUTY_MAX))
    else $error("duty outside clamp range");

  // zero error after zero error keeps the held values
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (load && !in_data.tag.err_pos && !in_data.tag.err_neg &&
     !in_data.tag.prev_pos && !in_data.tag.prev_neg)
    |=> (left_duty == $past(left_duty)) && (right_duty == $past(right_duty)))
    else $error("held duty changed on zero error");

  // a positive error item reports a positive angle error
  a_err_sign: assert property (@(posedge clk) disable iff (rst)
    (load && in_data.tag.err_pos)
    |=> out_valid && !angle_error[ERR_W-1] && (angle_error != '0))
    else $error("angle error sign lost");

endmodule

`default_nettype wire
